FILE: design/lfu_pkg.sv
// Shared types, constants and codes for the LFU cache with LRU tie-break.
`default_nettype none
package lfu_pkg;
  localparam int CAPACITY_DEF = 16;
  localparam int SLOT_W = 8;            // holds any index or rank up to 256 entries
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;
  localparam logic [4:0] CAP_RESET = 5'd16;
  localparam logic signed [31:0] READ_MISS = -32'sd1;

  // Search record handed from cell to cell.
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] found_idx;
    logic [31:0]       found_data;
    logic [SLOT_W-1:0] found_rank;
    logic              has_victim;
    logic [SLOT_W-1:0] victim_idx;
    logic [31:0]       victim_count;
    logic [SLOT_W-1:0] victim_rank;
    logic              has_free;
    logic [SLOT_W-1:0] free_idx;
  } lfu_scan_t;

  // Update broadcast to every cell.
  typedef struct packed {
    logic              touch_en;
    logic              write_data;
    logic [SLOT_W-1:0] tgt_idx;
    logic [SLOT_W-1:0] tgt_rank;
    logic              evict_en;
    logic [SLOT_W-1:0] victim_idx;
    logic [SLOT_W-1:0] victim_rank;
    logic              insert_en;
    logic [SLOT_W-1:0] slot_idx;
    logic [31:0]       key;
    logic [31:0]       data;
  } lfu_upd_t;
endpackage
`default_nettype wire

FILE: design/lfu_ifs.sv
// Handshake channel interfaces for requests, responses and configuration.
`default_nettype none
interface lfu_req_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] key;
  logic signed [31:0] value;
  modport source (output valid, command, key, value, input ready);
  modport sink (input valid, command, key, value, output ready);
endinterface

interface lfu_rsp_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] read_value;
  modport source (output valid, hit, read_value, input ready);
  modport sink (input valid, hit, read_value, output ready);
endinterface

interface lfu_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: design/lfu_cell.sv
// One cache entry: holds its state, joins the search record, applies updates.
`default_nettype none
module lfu_cell
  import lfu_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int IDX = 0
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] search_key,
  input  wire lfu_scan_t   scan_in,
  output      lfu_scan_t   scan_out,
  input  wire lfu_upd_t    upd
);
  localparam int RW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(IDX);

  logic          valid;
  logic [31:0]   key;
  logic [31:0]   data;
  logic [31:0]   count;
  logic [RW-1:0] rank;
  logic [SLOT_W-1:0] rank_w;
  lfu_scan_t     scan_next;
  logic          better;

  assign rank_w = SLOT_W'(rank);

  always_comb begin
    scan_next = scan_in;
    if (valid && key == search_key && !scan_in.found) begin
      scan_next.found      = 1'b1;
      scan_next.found_idx  = MY_IDX;
      scan_next.found_data = data;
      scan_next.found_rank = rank_w;
    end
    better = valid && (!scan_in.has_victim || count < scan_in.victim_count ||
             (count == scan_in.victim_count && rank_w > scan_in.victim_rank));
    if (better) begin
      scan_next.has_victim   = 1'b1;
      scan_next.victim_idx   = MY_IDX;
      scan_next.victim_count = count;
      scan_next.victim_rank  = rank_w;
    end
    if (!valid && !scan_in.has_free) begin
      scan_next.has_free = 1'b1;
      scan_next.free_idx = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    scan_out <= scan_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (upd.touch_en) begin
      if (upd.tgt_idx == MY_IDX) begin
        rank <= '0;
        if (count != 32'hFFFF_FFFF) count <= count + 32'd1;
        if (upd.write_data) data <= upd.data;
      end else if (valid && rank_w < upd.tgt_rank) begin
        rank <= rank + RW'(1);
      end
    end else if (upd.insert_en || upd.evict_en) begin
      if (upd.insert_en && upd.slot_idx == MY_IDX) begin
        valid <= 1'b1;
        key   <= upd.key;
        data  <= upd.data;
        count <= 32'd1;
        rank  <= '0;
      end else if (upd.evict_en && upd.victim_idx == MY_IDX) begin
        valid <= 1'b0;
      end else if (valid) begin
        rank <= rank - RW'(upd.evict_en && rank_w > upd.victim_rank)
                     + RW'(upd.insert_en);
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/lfu_cache_lru_tiebreak.sv
// Top level: LFU cache with LRU tie-break built from a row of entry cells.
// One request is in flight at a time: a new one is taken only once the last has left the
// apply step. The search record walks the cell row one cell per cycle, then the apply step
// updates the cells and registers the response. A response still waiting at the output
// holds the next request in that final step.
// Reset (rst, synchronous): all entries invalid, occupancy zero, capacity 16.
`default_nettype none
module lfu_cache_lru_tiebreak
  import lfu_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input wire logic clk,
  input wire logic rst,
  lfu_req_if.sink   req,
  lfu_rsp_if.source rsp,
  lfu_cfg_if.sink   cfg
);
  localparam int OW = $clog2(CAPACITY + 1);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]        state;
  logic [SLOT_W-1:0] cnt;
  logic              cmd;
  logic [31:0]       key;
  logic [31:0]       value;
  logic [4:0]        cap;
  logic [OW-1:0]     occ;
  logic              rsp_valid;
  logic              rsp_hit;
  logic [31:0]       rsp_data;

  lfu_scan_t scan [CAPACITY+1];
  lfu_scan_t last;
  lfu_upd_t  upd;

  logic [8:0] cap_eff;
  logic       do_apply, evict, insert, touch;

  // Configuration is always taken.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg.valid) begin
      cap <= cfg.data;
    end
  end

  assign req.ready      = (state == ST_IDLE);
  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_hit;
  assign rsp.read_value = rsp_data;

  // Row of cells; an empty record enters at the head.
  assign scan[0] = '0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lfu_cell #(.CAPACITY(CAPACITY), .IDX(i)) u_cell (
      .clk(clk), .rst(rst), .search_key(key),
      .scan_in(scan[i]), .scan_out(scan[i+1]), .upd(upd)
    );
  end
  assign last = scan[CAPACITY];

  always_comb begin
    cap_eff = (9'(cap) > 9'(CAPACITY)) ? 9'(CAPACITY) : 9'(cap);
    // Hold the final step while the previous response is still waiting.
    do_apply = (state == ST_APPLY) && (!rsp_valid || rsp.ready);
    touch  = last.found && (cmd == CMD_GET || cap_eff != 9'd0);
    evict  = (cmd == CMD_PUT) && cap_eff != 9'd0 && !last.found &&
             9'(occ) >= cap_eff && last.has_victim;
    insert = (cmd == CMD_PUT) && cap_eff != 9'd0 && !last.found &&
             (evict || last.has_free);
    upd             = '0;
    upd.touch_en    = do_apply && touch;
    upd.write_data  = (cmd == CMD_PUT);
    upd.tgt_idx     = last.found_idx;
    upd.tgt_rank    = last.found_rank;
    upd.evict_en    = do_apply && evict;
    upd.victim_idx  = last.victim_idx;
    upd.victim_rank = last.victim_rank;
    upd.insert_en   = do_apply && insert;
    // Fill the lowest free entry, or the victim's if that comes first.
    upd.slot_idx    = (evict && !(last.has_free && last.free_idx < last.victim_idx)) ?
                      last.victim_idx : last.free_idx;
    upd.key         = key;
    upd.data        = value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occ       <= '0;
      rsp_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      // Drop the response once taken, unless a new one replaces it this cycle.
      if (rsp_valid && rsp.ready && !do_apply) rsp_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            cmd   <= req.command;
            key   <= req.key;
            value <= req.value;
            cnt   <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Advance until the record has passed the last cell.
          if (cnt == SLOT_W'(CAPACITY - 1)) begin
            state <= ST_APPLY;
          end else begin
            cnt <= cnt + SLOT_W'(1);
          end
        end
        ST_APPLY: begin
          if (do_apply) begin
            rsp_valid <= 1'b1;
            rsp_hit   <= last.found;
            if (cmd == CMD_GET) begin
              rsp_data <= last.found ? last.found_data : READ_MISS;
            end else begin
              rsp_data <= '0;
            end
            occ   <= occ - OW'(evict) + OW'(insert);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: design/lfu_chk.sv
// Port-level checker for the LFU cache, bound to the top level.
`default_nettype none
module lfu_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic        rsp_hit,
  input wire logic [31:0] rsp_value
);
  // One request in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another was in flight");

  // A miss yields -1 (get) or 0 (put).
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_hit |-> (rsp_value == 32'hFFFF_FFFF || rsp_value == 32'd0))
    else $error("miss with unexpected value");

  // No response right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");
endmodule

bind lfu_cache_lru_tiebreak lfu_chk u_lfu_chk (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_hit(rsp.hit), .rsp_value(rsp.read_value)
);
`default_nettype wire

FILE: dv/lfu_cache_lru_tiebreak_sb.sv
// Scoreboard class: cache predictor and queue of expected responses.
`timescale 1ns / 1ps
class lfu_scoreboard;
  localparam int DEPTH = 16;
  bit          slot_valid[DEPTH];
  bit [31:0]   slot_key[DEPTH];
  bit [31:0]   slot_data[DEPTH];
  bit [31:0]   slot_count[DEPTH];
  int unsigned slot_rank[DEPTH];
  int unsigned fill;
  bit [4:0]    capacity;
  bit          exp_hit_q[$];
  bit [31:0]   exp_value_q[$];
  int          errors;

  function new();
    fill = 0;
    capacity = lfu_pkg::CAP_RESET;
    errors = 0;
    foreach (slot_valid[i]) slot_valid[i] = 0;
  endfunction

  function void set_capacity(bit [4:0] c);
    capacity = c;
  endfunction

  function int pending();
    return exp_hit_q.size();
  endfunction

  // Raise recency and count of slot s.
  function void promote(int s);
    int unsigned r;
    r = slot_rank[s];
    for (int i = 0; i < DEPTH; i++)
      if (slot_valid[i] && i != s && slot_rank[i] < r) slot_rank[i]++;
    slot_rank[s] = 0;
    if (slot_count[s] != 32'hFFFF_FFFF) slot_count[s]++;
  endfunction

  function void drop_victim();
    int v;
    v = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (!slot_valid[i]) continue;
      if (v < 0 || slot_count[i] < slot_count[v] ||
          (slot_count[i] == slot_count[v] && slot_rank[i] > slot_rank[v])) v = i;
    end
    if (v < 0) return;
    for (int i = 0; i < DEPTH; i++)
      if (slot_valid[i] && slot_rank[i] > slot_rank[v]) slot_rank[i]--;
    slot_valid[v] = 0;
    if (fill > 0) fill--;
  endfunction

  function void add_entry(bit [31:0] k, bit [31:0] d);
    int s;
    s = -1;
    for (int i = 0; i < DEPTH; i++)
      if (!slot_valid[i]) begin
        s = i;
        break;
      end
    if (s < 0) return;
    for (int i = 0; i < DEPTH; i++)
      if (slot_valid[i]) slot_rank[i]++;
    slot_valid[s] = 1;
    slot_key[s] = k;
    slot_data[s] = d;
    slot_count[s] = 1;
    slot_rank[s] = 0;
    fill++;
  endfunction

  // Note an accepted request and queue its expected response.
  function void note_request(logic cmd, bit [31:0] k, bit [31:0] d);
    int s;
    int unsigned cap;
    s = -1;
    cap = (capacity > DEPTH) ? DEPTH : capacity;
    for (int i = 0; i < DEPTH; i++)
      if (slot_valid[i] && slot_key[i] == k) begin
        s = i;
        break;
      end
    exp_hit_q.push_back(s >= 0);
    if (cmd == lfu_pkg::CMD_GET) begin
      if (s >= 0) begin
        exp_value_q.push_back(slot_data[s]);
        promote(s);
      end else begin
        exp_value_q.push_back(lfu_pkg::READ_MISS);
      end
      return;
    end
    exp_value_q.push_back(32'd0);
    if (cap == 0) return;
    if (s >= 0) begin
      slot_data[s] = d;
      promote(s);
    end else begin
      if (fill >= cap) drop_victim();
      add_entry(k, d);
    end
  endfunction

  function void check_response(logic hit, logic [31:0] value);
    bit eh;
    bit [31:0] ev;
    if (exp_hit_q.size() == 0) begin
      $display("%0t: unexpected response hit=%0b value=%h", $time, hit, value);
      errors++;
      return;
    end
    eh = exp_hit_q.pop_front();
    ev = exp_value_q.pop_front();
    if (hit !== eh) begin
      $display("%0t: hit mismatch expected %0b actual %0b", $time, eh, hit);
      errors++;
    end
    if (value !== ev) begin
      $display("%0t: read_value mismatch expected %h actual %h", $time, ev, value);
      errors++;
    end
  endfunction
endclass

FILE: dv/lfu_cache_lru_tiebreak_tb.sv
// Top-level testbench for the LFU cache with LRU tie-break.
`timescale 1ns / 1ps
module lfu_cache_lru_tiebreak_tb;
  import lfu_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst;

  lfu_req_if req_ch ();
  lfu_rsp_if rsp_ch ();
  lfu_cfg_if cfg_ch ();

  lfu_cache_lru_tiebreak DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source),
    .cfg(cfg_ch.sink)
  );

  lfu_scoreboard sb;

  // Receiver and sender control: random stalls, a long hold-off, sender gaps, none near the end.
  bit rsp_stall_en;
  bit hold_rsp;
  bit send_gaps;
  int idle_cycles;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Count cycles with no transaction on any channel; end the run when stuck.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("lfu_cache_lru_tiebreak regression: fail");
        $finish;
      end
    end
  end

  // Check every response transaction against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_response(rsp_ch.hit, rsp_ch.read_value);
  end

  // Drive ready in bursts; hold low for a long stretch on request.
  initial begin
    int n;
    rsp_ch.ready = 0;
    @(posedge clk);
    forever begin
      if (hold_rsp) begin
        rsp_ch.ready <= 0;
        @(posedge clk);
      end else if (rsp_stall_en && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 12);
        rsp_ch.ready <= 0;
        repeat (n) @(posedge clk);
      end else begin
        n = $urandom_range(1, 12);
        rsp_ch.ready <= 1;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Offer one request and wait for its transaction; gaps go before it.
  task automatic send_request(logic cmd, logic [31:0] k, logic [31:0] d);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_ch.valid <= 1;
    req_ch.command <= cmd;
    req_ch.key <= k;
    req_ch.value <= d;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(cmd, k, d);
  endtask

  task automatic end_request();
    req_ch.valid <= 0;
  endtask

  // Wait for all responses, then let the pipeline settle.
  task automatic drain();
    end_request();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [4:0] c);
    cfg_ch.valid <= 1;
    cfg_ch.data <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_capacity(c);
    cfg_ch.valid <= 0;
    @(posedge clk);
  endtask

  // Keys come from a small pool so that hits, updates and evictions are common.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return $urandom();
      default: return $urandom_range(0, 23);
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++)
      send_request(($urandom_range(0, 2) == 0) ? CMD_PUT : CMD_GET,
                   pick_key(), pick_value());
  endtask

  initial begin
    logic [4:0] caps[6];
    sb = new();
    idle_cycles = 0;
    rsp_stall_en = 1;
    hold_rsp = 0;
    send_gaps = 1;
    rst = 1;
    req_ch.valid = 0;
    req_ch.command = CMD_GET;
    req_ch.key = 0;
    req_ch.value = 0;
    cfg_ch.valid = 0;
    cfg_ch.data = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: miss on empty, extreme keys and values, update, hit.
    send_request(CMD_GET, 32'h8000_0000, 0);
    send_request(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_PUT, 32'd0, 32'd0);
    send_request(CMD_GET, 32'h8000_0000, 32'h1234_5678);
    send_request(CMD_PUT, 32'h7FFF_FFFF, 32'h5555_AAAA);
    send_request(CMD_GET, 32'h7FFF_FFFF, 0);
    send_request(CMD_GET, 32'hFFFF_FFFF, 0);
    send_request(CMD_GET, 32'd0, 0);
    drain();

    // Capacity zero: puts change nothing, gets still hit.
    write_capacity(5'd0);
    send_request(CMD_PUT, 32'h8000_0000, 32'd1);
    send_request(CMD_PUT, 32'd77, 32'd2);
    send_request(CMD_GET, 32'h8000_0000, 0);
    send_request(CMD_GET, 32'd77, 0);
    drain();

    // Capacity one with four entries present: lowered below occupancy.
    write_capacity(5'd1);
    send_request(CMD_PUT, 32'd5, 32'd50);
    send_request(CMD_PUT, 32'd6, 32'd60);
    send_request(CMD_GET, 32'd5, 0);
    drain();

    // Above the table size: treated as full size; fill and evict on tie.
    write_capacity(5'd31);
    for (int i = 0; i < 18; i++) send_request(CMD_PUT, 32'd100 + i, i);
    drain();

    // Long hold-off: receiver stalls while the sender keeps offering.
    hold_rsp = 1;
    fork
      random_phase(40);
      begin
        repeat (300) @(posedge clk);
        hold_rsp = 0;
      end
    join
    drain();

    // Random phases across capacities, extremes included.
    caps[0] = 5'd16; caps[1] = 5'd2; caps[2] = 5'd0;
    caps[3] = 5'd8;  caps[4] = 5'd17; caps[5] = 5'd4;
    for (int p = 0; p < 6; p++) begin
      write_capacity(p < 5 ? caps[p] : 5'($urandom_range(1, 31)));
      random_phase(170);
      drain();
    end

    // Last stretch with no idling on either side.
    write_capacity(5'd16);
    rsp_stall_en = 0;
    send_gaps = 0;
    random_phase(120);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("lfu_cache_lru_tiebreak regression: pass");
    end else begin
      $display("lfu_cache_lru_tiebreak regression: fail");
    end
    $finish;
  end
endmodule
